// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bole_pkg.sv -----
package bole_pkg;

  localparam int REQ_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int QDEPTH      = 2;

  // request codes as they arrive on the input channel
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_END   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TRAVERSE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic [2:0] {
    OP_INS_FRONT,
    OP_INS_END,
    OP_DEL_LAST,
    OP_DEL_POS,
    OP_TRAVERSE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   idx;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_TRAV
  } bk_state_t;

endpackage

// ----- rtl/core/bounded_ordered_list_engine_top.sv -----
// channel | dir | tdata                                  | tuser        | tlast
// in_     | in  | value[31:0], position[39:32]           | req_type[2:0]| -
// out_    | out | item_value[31:0], entry_count[36:32]   | status[1:0]  | item_last
//
// a request passes an input register and a two-entry command queue, then executes
// on the cell row: insert-front shifts all cells, delete-by-position shifts those above it.
// a traverse is accepted, then emits cell 0 and rotates the row once per entry, and
// the command queue keeps filling meanwhile.
// synchronous active-low reset empties the list; cell contents are not cleared.
// back pressure on out_ holds the result register and stalls the traverse rotate.
module bounded_ordered_list_engine_top
  import bole_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], position[39:32]
  input  logic [REQ_W-1:0]       in_tuser,   // req_type[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // item_value[31:0], entry_count[36:32]
  output logic [STATUS_W-1:0]    out_tuser,  // status[1:0]
  output logic                   out_tlast   // item_last
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  bole_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bole_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  bole_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/core/bole_front.sv -----
module bole_front
  import bole_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [POS_W-1:0] pos;
  logic             take;

  assign pos       = in_tdata[VALUE_W +: POS_W];
  assign in_tready = !vld_r || cmd_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    cmd_nxt       = cmd_r;
    cmd_nxt.value = in_tdata[VALUE_W-1:0];
    // positions 0 and 1 both name the head
    cmd_nxt.idx   = (pos <= POS_W'(1)) ? '0 : pos - POS_W'(1);
    case (in_tuser)
      REQ_INS_FRONT: cmd_nxt.op = OP_INS_FRONT;
      REQ_INS_END:   cmd_nxt.op = OP_INS_END;
      REQ_DEL_LAST:  cmd_nxt.op = OP_DEL_LAST;
      REQ_DEL_POS:   cmd_nxt.op = OP_DEL_POS;
      REQ_TRAVERSE:  cmd_nxt.op = OP_TRAVERSE;
      default:       cmd_nxt.op = OP_NOP;
    endcase
    if (!take) cmd_nxt = cmd_r;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take)           vld_nxt = 1'b1;
    else if (cmd_ready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

endmodule

// ----- rtl/core/bole_cmdq.sv -----
module bole_cmdq
  import bole_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t            slot_r [QDEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (pop)  rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (push && !pop)      cnt_nxt = cnt_r + (PW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_cmd;
  end

endmodule

// ----- rtl/core/bole_back.sv -----
module bole_back
  import bole_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // item_value[31:0], entry_count[36:32], zero pad
  output logic [STATUS_W-1:0]    out_tuser,   // status[1:0]
  output logic                   out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] cell_r [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [CW-1:0]         fill_r, fill_nxt, cnt_r, cnt_nxt;
  bk_state_t             state_r, state_nxt;

  logic                  out_free, pop, trav_step, trav_last, trav_start, load;
  logic                  full, empty;
  logic [STATUS_W-1:0]   ex_status;
  logic signed [63:0]    in64, out64;
  logic [DATA_WIDTH-1:0] wval;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  assign out_free   = !out_valid_r || out_tready;
  assign full       = (fill_r == CW'(CAPACITY));
  assign empty      = (fill_r == '0);
  assign pop        = cmd_valid && cmd_ready;
  assign trav_last  = (cnt_r + CW'(1) == fill_r);
  assign trav_start = pop && (cmd.op == OP_TRAVERSE) && !empty;
  assign load       = (pop && !trav_start) || trav_step;

  assign in64  = 64'(signed'(cmd.value));
  assign wval  = in64[DATA_WIDTH-1:0];
  assign out64 = 64'(signed'(cell_r[0]));

  // list update: at most one shift of the cell row per command, or one rotate per readout step
  always_comb begin
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    ex_status = ST_OK;
    for (int i = 0; i < CAPACITY; i++) cell_nxt[i] = cell_r[i];
    if (pop) begin
      case (cmd.op)
        OP_INS_FRONT: begin
          if (full) begin
            ex_status = ST_FULL;
          end else begin
            cell_nxt[0] = wval;
            for (int i = 1; i < CAPACITY; i++) cell_nxt[i] = cell_r[i-1];
            fill_nxt = fill_r + CW'(1);
          end
        end
        OP_INS_END: begin
          if (full) begin
            ex_status = ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++)
              if (CW'(i) == fill_r) cell_nxt[i] = wval;
            fill_nxt = fill_r + CW'(1);
          end
        end
        OP_DEL_LAST: begin
          if (empty) ex_status = ST_EMPTY;
          else       fill_nxt  = fill_r - CW'(1);
        end
        OP_DEL_POS: begin
          if (empty) begin
            ex_status = ST_EMPTY;
          end else if (32'(cmd.idx) >= 32'(fill_r)) begin
            ex_status = ST_BADPOS;
          end else begin
            for (int i = 0; i < CAPACITY - 1; i++)
              if (32'(i) >= 32'(cmd.idx)) cell_nxt[i] = cell_r[i+1];
            fill_nxt = fill_r - CW'(1);
          end
        end
        OP_TRAVERSE: begin
          if (empty) ex_status = ST_EMPTY;
          cnt_nxt = '0;
        end
        default: ex_status = ST_OK;
      endcase
    end else if (trav_step) begin
      // rotate the live part so the list is back in order after fill_r steps
      for (int i = 0; i < CAPACITY; i++) begin
        if (CW'(i) == fill_r - CW'(1)) cell_nxt[i] = cell_r[0];
        else if (i < CAPACITY - 1)     cell_nxt[i] = cell_r[(i + 1) % CAPACITY];
      end
      cnt_nxt = trav_last ? '0 : cnt_r + CW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (trav_start) state_nxt = BK_TRAV;
      BK_TRAV: if (trav_step && trav_last) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    trav_step = 1'b0;
    case (state_r)
      BK_IDLE: cmd_ready = out_free;
      BK_TRAV: trav_step = out_free;
      default: begin
        cmd_ready = 1'b0;
        trav_step = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (trav_step) begin
        out_status_nxt = ST_OK;
        out_value_nxt  = out64[VALUE_W-1:0];
        out_last_nxt   = trav_last;
        out_count_nxt  = COUNT_W'(fill_r);
      end else begin
        out_status_nxt = ex_status;
        out_value_nxt  = '0;
        out_last_nxt   = 1'b1;
        out_count_nxt  = COUNT_W'(fill_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) cell_r[i] <= cell_nxt[i];
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - VALUE_W - COUNT_W)'(0), out_count_r, out_value_r};

endmodule

// ----- rtl/core/bole_checker.sv -----
`include "assert_macros.svh"

module bole_checker
  import bole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser,
  input logic                   out_tlast
);

  logic [COUNT_W-1:0] count;
  assign count = out_tdata[VALUE_W +: COUNT_W];

  // only readout entries come without the last mark, and those are always ok
  `CHK_NOW(a_mid_ok, out_tvalid && !out_tlast, out_tuser == ST_OK, "non-final result not ok")
  // a refused insert reports a full list
  `CHK_NOW(a_full_cnt, out_tvalid && out_tuser == ST_FULL, count == COUNT_W'(CAPACITY), "full status with wrong count")
  // an empty-list status means nothing is held
  `CHK_NOW(a_empty_cnt, out_tvalid && out_tuser == ST_EMPTY, count == '0, "empty status with entries held")
  `CHK_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled transfer changed")

endmodule

bind bounded_ordered_list_engine_top bole_checker #(.CAPACITY(CAPACITY)) u_bole_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
